[sv/extent_request_splitter_unit_macros.svh]
// Assertion macros shared by the extent request splitter modules.
// Every macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef EXTENT_REQUEST_SPLITTER_UNIT_MACROS_SVH
`define EXTENT_REQUEST_SPLITTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/ers_pkg.sv]
// Package for the extent request splitter: field widths, shift limits and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ers_pkg;

    localparam int VOL_W       = 32;
    localparam int OFFSET_W    = 48;
    localparam int LENGTH_W    = 32;
    localparam int IDX_W       = 39;
    localparam int BASE_W      = 48;
    localparam int DOFF_W      = 32;
    localparam int INEXT_W     = 30;
    localparam int PLEN_W      = 31;
    localparam int SHIFT_W     = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd20;

    localparam int MAX_PIECES_DEF = 64;

    typedef struct packed {
        logic load;
        logic check;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic zero_len;
        logic too_long;
        logic last_piece;
        logic out_free;
    } t_status;

endpackage

[sv/ers_if.sv]
// Handshake interfaces for the request and piece channels.
// Depends on ers_pkg for the field widths.
`timescale 1ns / 1ps

interface ers_req_if;
    logic                          valid;
    logic                          ready;
    logic [ers_pkg::VOL_W-1:0]     req_volume;
    logic [ers_pkg::OFFSET_W-1:0]  offset;
    logic [ers_pkg::LENGTH_W-1:0]  length;

    modport source (output valid, output req_volume, output offset, output length,
                    input ready);
    modport sink   (input valid, input req_volume, input offset, input length,
                    output ready);
endinterface

interface ers_piece_if;
    logic                          valid;
    logic                          ready;
    logic [ers_pkg::VOL_W-1:0]     volume_tag;
    logic [ers_pkg::IDX_W-1:0]     extent_index;
    logic [ers_pkg::BASE_W-1:0]    extent_base;
    logic [ers_pkg::DOFF_W-1:0]    data_start;
    logic [ers_pkg::INEXT_W-1:0]   offset_in_extent;
    logic [ers_pkg::PLEN_W-1:0]    piece_length;
    logic                          last;
    logic                          too_long;

    modport source (output valid, output volume_tag, output extent_index,
                    output extent_base, output data_start, output offset_in_extent,
                    output piece_length, output last, output too_long, input ready);
    modport sink   (input valid, input volume_tag, input extent_index,
                    input extent_base, input data_start, input offset_in_extent,
                    input piece_length, input last, input too_long, output ready);
endinterface

[sv/extent_request_splitter_unit.sv]
// Top level of the extent request splitter: controller plus datapath.
// Depends on ers_pkg, ers_if, ers_ctrl and ers_datapath.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Carries
//  i_req     in         valid / ready          req_volume, offset, length
//  o_piece   out        valid / ready          one piece per extent touched
//  cfg       in         i_cfg_valid/o_cfg_ready extent_shift (log2 of extent size)
//
//  A request is accepted in the idle state, its length is checked against the piece
//  limit, then one piece a cycle leaves the single output register while it is free.
//  Zero-length and refused requests yield a single piece at the check and no walk.
//  Reset is synchronous and active low; it restores an extent shift of 20.
//  A stall on o_piece holds the output register and pauses the piece walk.
//  The configuration port is always ready and should only be written while idle.

module extent_request_splitter_unit #(
    parameter int MAX_PIECES = ers_pkg::MAX_PIECES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ers_req_if.sink                      i_req,
    ers_piece_if.source                  o_piece,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ers_pkg::SHIFT_W-1:0]  i_cfg_data
);
    import ers_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    // The shift register is a single flop bank, so writes are taken at once.
    assign o_cfg_ready = 1'b1;
    assign i_req.ready = w_in_ready;

    // The controller sequences accept, length check and the piece walk.
    ers_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the request, the walk registers and the output register.
    ers_datapath #(
        .MAX_PIECES (MAX_PIECES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_req_volume (i_req.req_volume),
        .i_offset     (i_req.offset),
        .i_length     (i_req.length),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_piece      (o_piece)
    );

endmodule

[sv/ers_ctrl.sv]
// Controller state machine of the extent request splitter.
// Depends on ers_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "extent_request_splitter_unit_macros.svh"

module ers_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ers_pkg::t_status i_status,
    output ers_pkg::t_cmd   o_cmd
);
    import ers_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.out_free) begin
                    o_cmd.check = 1'b1;
                    if (i_status.zero_len || i_status.too_long) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_piece) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ERS_ASSERT_NEXT(a_accept_to_check, i_in_valid && o_in_ready, r_state == S_CHECK, "accepted request did not enter the check state")
    `ERS_ASSERT_SAME(a_emit_needs_room, o_cmd.emit || o_cmd.check, i_status.out_free, "result produced while output register full")
    `ERS_ASSERT_NEXT(a_last_to_idle, o_cmd.emit && i_status.last_piece, o_in_ready, "not ready for a new request after the last piece")

endmodule

[sv/ers_datapath.sv]
// Datapath of the extent request splitter: configuration register, walk
// registers and the output register. Depends on ers_pkg, ers_if and the macros.
`timescale 1ns / 1ps
`include "extent_request_splitter_unit_macros.svh"

module ers_datapath #(
    parameter int MAX_PIECES = ers_pkg::MAX_PIECES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ers_pkg::SHIFT_W-1:0]   i_cfg_data,
    input  logic [ers_pkg::VOL_W-1:0]     i_req_volume,
    input  logic [ers_pkg::OFFSET_W-1:0]  i_offset,
    input  logic [ers_pkg::LENGTH_W-1:0]  i_length,
    input  ers_pkg::t_cmd                 i_cmd,
    output ers_pkg::t_status              o_status,
    ers_piece_if.source                   o_piece
);
    import ers_pkg::*;

    localparam logic [LENGTH_W:0] LIMIT_M1 = (LENGTH_W+1)'(MAX_PIECES - 1);

    logic [SHIFT_W-1:0]   r_cfg_shift;
    logic [SHIFT_W-1:0]   r_s;
    logic [VOL_W-1:0]     r_vol;
    logic [IDX_W-1:0]     r_ext;
    logic [INEXT_W-1:0]   r_inext;
    logic [LENGTH_W-1:0]  r_left;
    logic [DOFF_W-1:0]    r_done;
    logic                 r_first;

    logic                 r_o_valid;
    logic [VOL_W-1:0]     r_o_vol;
    logic [IDX_W-1:0]     r_o_idx;
    logic [BASE_W-1:0]    r_o_base;
    logic [DOFF_W-1:0]    r_o_doff;
    logic [INEXT_W-1:0]   r_o_inext;
    logic [PLEN_W-1:0]    r_o_plen;
    logic                 r_o_last;
    logic                 r_o_tl;

    logic [SHIFT_W-1:0]   ld_s;
    logic [PLEN_W-1:0]    ld_mask;
    logic [LENGTH_W:0]    end_byte;
    logic [LENGTH_W:0]    cnt_m1;
    logic                 too_long;
    logic [PLEN_W-1:0]    room;
    logic [LENGTH_W-1:0]  room_w;
    logic [LENGTH_W-1:0]  plen_w;
    logic                 is_last;
    logic [BASE_W-1:0]    base;
    logic                 out_free;

    // Shift is clamped into the supported extent sizes when a request is taken.
    always_comb begin
        if (r_cfg_shift < SHIFT_MIN) begin
            ld_s = SHIFT_MIN;
        end else if (r_cfg_shift > SHIFT_MAX) begin
            ld_s = SHIFT_MAX;
        end else begin
            ld_s = r_cfg_shift;
        end
        ld_mask = (PLEN_W'(1) << ld_s) - PLEN_W'(1);
    end

    // Last byte relative to the first extent start, in extents, gives pieces - 1.
    assign end_byte = (LENGTH_W+1)'(r_inext) + (LENGTH_W+1)'(r_left) - (LENGTH_W+1)'(1);
    assign cnt_m1   = end_byte >> r_s;
    assign too_long = (r_left != '0) && (cnt_m1 > LIMIT_M1);

    assign room    = (PLEN_W'(1) << r_s) - (r_first ? PLEN_W'(r_inext) : PLEN_W'(0));
    assign room_w  = LENGTH_W'(room);
    assign plen_w  = (room_w < r_left) ? room_w : r_left;
    assign is_last = (plen_w == r_left);
    assign base    = BASE_W'(r_ext) << r_s;

    assign out_free = !r_o_valid || o_piece.ready;

    always_comb begin
        o_status.zero_len   = (r_left == '0);
        o_status.too_long   = too_long;
        o_status.last_piece = is_last;
        o_status.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_shift <= SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_shift <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s     <= ld_s;
            r_vol   <= i_req_volume;
            r_ext   <= IDX_W'(i_offset >> ld_s);
            r_inext <= i_offset[INEXT_W-1:0] & ld_mask[INEXT_W-1:0];
            r_left  <= i_length;
            r_done  <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.emit) begin
            r_left  <= r_left - plen_w;
            r_done  <= r_done + plen_w;
            r_ext   <= r_ext + IDX_W'(1);
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.check && (o_status.zero_len || too_long)) begin
            r_o_valid <= 1'b1;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_piece.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check && too_long) begin
            r_o_vol   <= r_vol;
            r_o_idx   <= '0;
            r_o_base  <= '0;
            r_o_doff  <= '0;
            r_o_inext <= '0;
            r_o_plen  <= '0;
            r_o_last  <= 1'b1;
            r_o_tl    <= 1'b1;
        end else if (i_cmd.check && o_status.zero_len) begin
            r_o_vol   <= r_vol;
            r_o_idx   <= r_ext;
            r_o_base  <= base;
            r_o_doff  <= '0;
            r_o_inext <= r_inext;
            r_o_plen  <= '0;
            r_o_last  <= 1'b1;
            r_o_tl    <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_vol   <= r_vol;
            r_o_idx   <= r_ext;
            r_o_base  <= base;
            r_o_doff  <= r_done;
            r_o_inext <= r_first ? r_inext : '0;
            r_o_plen  <= plen_w[PLEN_W-1:0];
            r_o_last  <= is_last;
            r_o_tl    <= 1'b0;
        end
    end

    assign o_piece.valid            = r_o_valid;
    assign o_piece.volume_tag       = r_o_vol;
    assign o_piece.extent_index     = r_o_idx;
    assign o_piece.extent_base      = r_o_base;
    assign o_piece.data_start       = r_o_doff;
    assign o_piece.offset_in_extent = r_o_inext;
    assign o_piece.piece_length     = r_o_plen;
    assign o_piece.last             = r_o_last;
    assign o_piece.too_long         = r_o_tl;

    `ERS_ASSERT_NEXT(a_shift_clamped, i_cmd.load, (r_s >= SHIFT_MIN) && (r_s <= SHIFT_MAX), "clamped shift out of range")
    `ERS_ASSERT_SAME(a_refusal_empty, r_o_valid && r_o_tl, (r_o_plen == '0) && r_o_last, "refused request carries a piece")
    `ERS_ASSERT_NEXT(a_last_drains, i_cmd.emit && is_last, r_left == '0, "bytes left after the last piece")

endmodule

[sim/extent_split_checker.sv]
// Checker for the extent request splitter: watches the request, piece and shift
// write channels, predicts the pieces of each request and compares them in order.
// Depends on ers_pkg and ers_if.
`timescale 1ns / 1ps

module extent_split_checker #(
    parameter int PIECE_LIMIT = ers_pkg::MAX_PIECES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ers_req_if                          req_bus,
    ers_piece_if                        piece_bus,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [ers_pkg::SHIFT_W-1:0] i_cfg_data,
    output int                          o_pending,
    output int                          o_errors
);
    import ers_pkg::*;

    localparam int EXTENT_CNT_W = 64 - int'(SHIFT_MIN);

    typedef struct packed {
        logic [VOL_W-1:0]   volume_tag;
        logic [IDX_W-1:0]   extent_index;
        logic [BASE_W-1:0]  extent_base;
        logic [DOFF_W-1:0]  data_start;
        logic [INEXT_W-1:0] offset_in_extent;
        logic [PLEN_W-1:0]  piece_length;
        logic               last;
        logic               too_long;
    } t_piece;

    t_piece             expected_pieces[$];
    t_piece             want;
    t_piece             got;
    logic [SHIFT_W-1:0] extent_shift_q;
    int                 err_cnt;

    // Cuts one request into the pieces that it should produce, in address order.
    task automatic split_request(input logic [VOL_W-1:0] vol, input logic [OFFSET_W-1:0] off,
                                 input logic [LENGTH_W-1:0] len);
        int unsigned     sh;
        longint unsigned size;
        longint unsigned inext;
        longint unsigned count;
        longint unsigned remaining;
        longint unsigned done;
        longint unsigned extent;
        longint unsigned room;
        longint unsigned plen;
        t_piece          p;
        sh = extent_shift_q;
        if (sh < SHIFT_MIN) sh = SHIFT_MIN;
        if (sh > SHIFT_MAX) sh = SHIFT_MAX;
        size   = 64'd1 << sh;
        inext  = 64'(off) & (size - 1);
        extent = 64'(off) >> sh;
        p = '0;
        p.volume_tag = vol;
        if (len == 0) begin
            p.extent_index     = extent[IDX_W-1:0];
            p.extent_base      = BASE_W'(extent << sh);
            p.offset_in_extent = inext[INEXT_W-1:0];
            p.last             = 1'b1;
            expected_pieces.insert(expected_pieces.size(), p);
            return;
        end
        count = ((inext + 64'(len) - 1) >> sh) + 1;
        if (count > PIECE_LIMIT) begin
            p.last     = 1'b1;
            p.too_long = 1'b1;
            expected_pieces.insert(expected_pieces.size(), p);
            return;
        end
        remaining = 64'(len);
        done      = 0;
        while (remaining != 0) begin
            room = size - ((done == 0) ? inext : 64'd0);
            plen = (room < remaining) ? room : remaining;
            remaining -= plen;
            p.extent_index     = extent[IDX_W-1:0];
            p.extent_base      = BASE_W'(extent << sh);
            p.data_start       = done[DOFF_W-1:0];
            p.offset_in_extent = (done == 0) ? inext[INEXT_W-1:0] : '0;
            p.piece_length     = plen[PLEN_W-1:0];
            p.last             = (remaining == 0);
            expected_pieces.insert(expected_pieces.size(), p);
            done  += plen;
            extent = (extent + 1) & ((64'd1 << EXTENT_CNT_W) - 1);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            extent_shift_q = SHIFT_RESET;
            expected_pieces.delete();
            err_cnt = 0;
        end else begin
            // A piece leaving at this edge always belongs to an earlier request.
            if (piece_bus.valid && piece_bus.ready) begin
                got = '{piece_bus.volume_tag, piece_bus.extent_index, piece_bus.extent_base,
                        piece_bus.data_start, piece_bus.offset_in_extent,
                        piece_bus.piece_length, piece_bus.last, piece_bus.too_long};
                if (expected_pieces.size() == 0) begin
                    $display("%0t: unexpected piece, expected none, actual %h", $time, got);
                    err_cnt++;
                end else begin
                    want = expected_pieces.pop_front();
                    check_field("volume_tag", 64'(want.volume_tag), 64'(got.volume_tag));
                    check_field("extent_index", 64'(want.extent_index), 64'(got.extent_index));
                    check_field("extent_base", 64'(want.extent_base), 64'(got.extent_base));
                    check_field("data_start", 64'(want.data_start), 64'(got.data_start));
                    check_field("offset_in_extent", 64'(want.offset_in_extent),
                                64'(got.offset_in_extent));
                    check_field("piece_length", 64'(want.piece_length), 64'(got.piece_length));
                    check_field("last", 64'(want.last), 64'(got.last));
                    check_field("too_long", 64'(want.too_long), 64'(got.too_long));
                end
            end
            // A request taken at this edge still sees the shift held before it.
            if (req_bus.valid && req_bus.ready)
                split_request(req_bus.req_volume, req_bus.offset, req_bus.length);
            if (i_cfg_valid && i_cfg_ready) extent_shift_q = i_cfg_data;
        end
        o_pending <= expected_pieces.size();
        o_errors  <= err_cnt;
    end

endmodule

[sim/tb_top.sv]
// Top of the extent request splitter testbench: clock, reset, request and piece
// stimulus, shift register writes and the verdict. Depends on ers_pkg, ers_if,
// extent_request_splitter_unit and extent_split_checker.
`timescale 1ns / 1ps

module tb_top;
    import ers_pkg::*;

    // The longest honest stretch without any transaction is the deliberate hold on the
    // piece side (HOLD_CYCLES) plus a sender gap and the way through the unit; the limit
    // is taken several times over that.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 300;
    // Every request yields a piece, so once the last piece has gone the unit has little
    // left to do, and this settle wait covers it.
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRESSURE_PHASE  = 2;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SHIFT_W-1:0] cfg_data;
    int                 pending;
    int                 errors;

    // calm switches off all idling on both sides; hold_asked requests the one long
    // stall on the piece side, which the ready driver marks as done once taken.
    bit                 calm = 1'b0;
    bit                 hold_asked = 1'b0;
    bit                 hold_done = 1'b0;
    int unsigned        eff_shift = 20;
    int unsigned        quiet_cycles = 0;

    ers_req_if   req_bus();
    ers_piece_if piece_bus();

    always #5 i_clk = ~i_clk;

    extent_request_splitter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_piece     (piece_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    extent_split_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_bus     (req_bus),
        .piece_bus   (piece_bus),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Offers one request and returns at the edge where the transaction completes. Valid
    // is left high so that a following request can go out back to back; a random gap
    // lowers it first.
    task automatic send_request(input logic [VOL_W-1:0] vol, input logic [OFFSET_W-1:0] off,
                                input logic [LENGTH_W-1:0] len);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_volume <= vol;
        req_bus.offset     <= off;
        req_bus.length     <= len;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // Draws a request whose length is scaled to the current extent size, so that most
    // requests split into a handful of pieces rather than being refused.
    task automatic send_random_request();
        longint unsigned size;
        longint unsigned off64;
        longint unsigned len64;
        longint unsigned span;
        int unsigned     pick;
        size  = 64'd1 << eff_shift;
        off64 = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
        pick  = $urandom_range(0, 99);
        if (pick < 55) begin
            len64 = ({$urandom, $urandom} % (8 * size)) + 1;
        end else if (pick < 67) begin
            // Straddle the piece limit: from two pieces below it to three above.
            span  = $urandom_range(62, 66);
            len64 = span * size - (off64 & (size - 1)) + $urandom_range(0, 2) - 1;
        end else if (pick < 77) begin
            len64 = 0;
            if ($urandom_range(0, 1) == 0) off64 &= ~(size - 1);
        end else if (pick < 87) begin
            len64 = $urandom;
        end else if (pick < 94) begin
            // Start a few extents below the top of the address space and may run past it.
            off64 = (64'd1 << OFFSET_W) - $urandom_range(1, 4) * size + (off64 & (size - 1));
            len64 = $urandom_range(1, 6) * size;
        end else begin
            len64 = $urandom_range(1, size);
        end
        if (len64 > 64'hFFFF_FFFF) len64 = 64'hFFFF_FFFF;
        send_request($urandom, off64[OFFSET_W-1:0], len64[LENGTH_W-1:0]);
    endtask

    // Lowers valid and waits until every predicted piece has come out, then lets the
    // unit finish whatever it still holds.
    task automatic settle();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_extent_shift(input logic [SHIFT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        eff_shift = (value < SHIFT_MIN) ? SHIFT_MIN : (value > SHIFT_MAX) ? SHIFT_MAX : value;
    endtask

    // Piece side: random stalls between runs of ready, plus the one long hold that lets
    // the unit fill up and push back on the request side.
    initial begin
        int unsigned run;
        piece_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_asked && !hold_done) begin
                piece_bus.ready <= 1'b0;
                run       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                piece_bus.ready <= 1'b0;
                run = $urandom_range(1, 8);
            end else begin
                piece_bus.ready <= 1'b1;
                run = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
            end
            repeat (run) @(posedge i_clk);
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (piece_bus.valid && piece_bus.ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_volume <= '0;
        req_bus.offset     <= '0;
        req_bus.length     <= '0;
        cfg_valid          <= 1'b0;
        cfg_data           <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the shift: zero length, aligned at address zero and unaligned at the very top,
        // a two-piece request and a maximal request that must be refused.
        send_request(32'h0000_0000, 48'h0000_0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0001, 48'h0000_0000_0123, 32'h0010_0000);
        send_request(32'h8000_0000, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        settle();

        // Smallest extents: exactly at the piece limit, one over it, the limit reached
        // from an unaligned start, a walk past the top of the address space and a
        // request of alternating bits.
        write_extent_shift(5'd9);
        send_request(32'h1234_5678, 48'h0000_0000_0000, 32'd32768);
        send_request(32'h8765_4321, 48'h0000_0000_0000, 32'd32769);
        send_request(32'h0F0F_0F0F, 48'h0000_0000_01FF, 32'd32257);
        send_request(32'hF0F0_F0F0, 48'hFFFF_FFFF_FA05, 32'd2560);
        send_request(32'h5555_5555, 48'h5555_5555_5555, 32'h0000_2AAA);
        settle();

        // Largest extents: full-size pieces, the largest length from the top address,
        // the complementary bit pattern and an aligned zero-length request.
        write_extent_shift(5'd30);
        send_request(32'hAAAA_AAAA, 48'h0000_0000_0000, 32'h8000_0000);
        send_request(32'h0000_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_0000, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
        send_request(32'h0000_0002, 48'h0001_4000_0000, 32'h0000_0000);
        settle();

        // Shift values outside the legal range are clamped to the nearest limit.
        write_extent_shift(5'd0);
        send_request(32'h0000_0003, 48'h0000_0000_03FF, 32'h0000_0400);
        send_request(32'h0000_0004, 48'h0000_0000_0000, 32'd32769);
        settle();
        write_extent_shift(5'd31);
        send_request(32'h0000_0005, 48'h0000_3FFF_FFFF, 32'h0000_0002);
        send_request(32'h0000_0006, 48'h0000_0000_0000, 32'h8000_0000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0:              write_extent_shift(5'd9);
                1:              write_extent_shift(5'd30);
                PRESSURE_PHASE: write_extent_shift(5'd12);
                default:        write_extent_shift(5'($urandom_range(0, 31)));
            endcase
            if (phase == PRESSURE_PHASE) hold_asked = 1'b1;
            if (phase == RANDOM_PHASES - 1) calm = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_request();
        end
        settle();

        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ers_pkg.sv
sv/ers_if.sv
sv/ers_ctrl.sv
sv/ers_datapath.sv
sv/extent_request_splitter_unit.sv
sim/extent_split_checker.sv
sim/tb_top.sv
